[rtl/tbp_pkg.sv]
// types, constants and counter helpers shared by the tournament branch predictor
package tbp_pkg;

   // request word: one resolved branch
   typedef struct packed {
      logic [9:0] pc_index;
      logic       is_cond;
      logic       is_indir;
      logic       outcome_taken;
   } req_type;

   // response word: prediction from the state before training
   typedef struct packed {
      logic predicted_taken;
      logic local_vote;
      logic global_vote;
      logic chose_global;
   } rsp_type;

   // one entry of the history-indexed table
   typedef struct packed {
      logic [1:0] chooser;
      logic [1:0] counter;
   } gword_type;

   localparam logic [2:0] LOCAL_MAX     = 3'd7;
   localparam logic [2:0] LOCAL_RESET   = 3'd3;
   localparam logic [1:0] TWO_BIT_MAX   = 2'd3;
   localparam logic [1:0] GLOBAL_RESET  = 2'd1;
   localparam logic [1:0] CHOOSER_RESET = 2'd1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // 3-bit saturating step
   function automatic logic [2:0] sat3(input logic [2:0] v, input logic up);
      logic [2:0] r;
      r = v;
      if (up) begin
         if (v != LOCAL_MAX) r = v + 3'd1;
      end else begin
         if (v != 3'd0) r = v - 3'd1;
      end
      return r;
   endfunction

   // 2-bit saturating step
   function automatic logic [1:0] sat2(input logic [1:0] v, input logic up);
      logic [1:0] r;
      r = v;
      if (up) begin
         if (v != TWO_BIT_MAX) r = v + 2'd1;
      end else begin
         if (v != 2'd0) r = v - 2'd1;
      end
      return r;
   endfunction

endpackage

[rtl/tournament_branch_predictor.sv]
// tournament branch predictor: local, global and chooser tables in block memories
// an accepted branch passes stage one and the table reads, then its response word is registered
// throughput: one branch per cycle unless busy; same-entry overlap is write-forwarded
// reset: synchronous; a clearing pass then fills the tables while busy is high;
// history is cleared at once
// rsp_strobe is high for exactly one cycle per word; the receiver cannot stall
module tournament_branch_predictor #(
   parameter int LOCAL_ENTRIES  = 1024,
   parameter int GLOBAL_ENTRIES = 4096,
   parameter int HISTORY_BITS   = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tbp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tbp_pkg::rsp_type rsp_data
);
   import tbp_pkg::*;

   localparam int LIDX_W      = $clog2(LOCAL_ENTRIES);
   localparam int GIDX_W      = $clog2(GLOBAL_ENTRIES);
   localparam int CLR_ENTRIES = (LOCAL_ENTRIES > GLOBAL_ENTRIES) ? LOCAL_ENTRIES
                                                                 : GLOBAL_ENTRIES;
   localparam int CLR_W       = $clog2(CLR_ENTRIES);

   // table storage
   logic [2:0] local_mem  [LOCAL_ENTRIES];
   gword_type  global_mem [GLOBAL_ENTRIES];

   state_type state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [HISTORY_BITS-1:0] hist_ff, hist_in;

   // stage one: branch whose table words are being read
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_voted_ff;
   logic              s1_taken_ff;
   logic [LIDX_W-1:0] s1_lidx_ff;
   logic [GIDX_W-1:0] s1_gidx_ff;
   logic [2:0]        lrd_ff;
   gword_type         grd_ff;

   // last writes, for forwarding into the following read
   logic              lwr_valid_ff, lwr_valid_in;
   logic [LIDX_W-1:0] lwr_idx_ff;
   logic [2:0]        lwr_data_ff;
   logic              gwr_valid_ff, gwr_valid_in;
   logic [GIDX_W-1:0] gwr_idx_ff;
   gword_type         gwr_data_ff;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [LIDX_W-1:0] lidx_rd;
   logic [GIDX_W-1:0] gidx_rd;
   logic [2:0]        lc;
   gword_type         gw;
   logic              lvote, gvote, cglob;
   logic [2:0]        lnew;
   gword_type         gnew;
   logic              lwe, gwe;
   logic [LIDX_W-1:0] lwa;
   logic [GIDX_W-1:0] gwa;
   logic [2:0]        lwd;
   gword_type         gwd;

   assign busy    = (state_ff != ST_RUN);
   assign accept  = start && !busy;
   assign lidx_rd = LIDX_W'(req_data.pc_index);
   assign gidx_rd = GIDX_W'(hist_ff);

   // clearing pass sequencer and history
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      hist_in  = hist_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_ENTRIES - 1)) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (accept) hist_in = {hist_ff[HISTORY_BITS-2:0], req_data.outcome_taken};
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // read data with forwarding of the write made at the read edge
   always_comb begin
      lc = lrd_ff;
      if (lwr_valid_ff && (lwr_idx_ff == s1_lidx_ff)) lc = lwr_data_ff;
      gw = grd_ff;
      if (gwr_valid_ff && (gwr_idx_ff == s1_gidx_ff)) gw = gwr_data_ff;
   end

   // prediction and training
   always_comb begin
      lvote = lc[2];
      gvote = gw.counter[1];
      cglob = gw.chooser[1];
      rsp_data_in.local_vote      = lvote;
      rsp_data_in.global_vote     = gvote;
      rsp_data_in.chose_global    = s1_voted_ff && cglob;
      rsp_data_in.predicted_taken = s1_voted_ff ? (cglob ? gvote : lvote) : 1'b1;
      rsp_strobe_in = s1_valid_ff;

      lnew = sat3(lc, s1_taken_ff);
      gnew.counter = sat2(gw.counter, s1_taken_ff);
      gnew.chooser = gw.chooser;
      if (lvote != gvote) gnew.chooser = sat2(gw.chooser, gvote == s1_taken_ff);

      lwr_valid_in = s1_valid_ff && s1_voted_ff;
      gwr_valid_in = s1_valid_ff;
      s1_valid_in  = accept;
   end

   // write port: clearing pass or training
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         lwe = 1'b1;
         gwe = 1'b1;
         lwa = clr_ff[LIDX_W-1:0];
         gwa = clr_ff[GIDX_W-1:0];
         lwd = LOCAL_RESET;
         gwd.chooser = CHOOSER_RESET;
         gwd.counter = GLOBAL_RESET;
      end else begin
         lwe = lwr_valid_in;
         gwe = gwr_valid_in;
         lwa = s1_lidx_ff;
         gwa = s1_gidx_ff;
         lwd = lnew;
         gwd = gnew;
      end
   end

   // local table
   always_ff @(posedge clock) begin
      if (lwe) local_mem[lwa] <= lwd;
      lrd_ff <= local_mem[lidx_rd];
   end

   // global and chooser table
   always_ff @(posedge clock) begin
      if (gwe) global_mem[gwa] <= gwd;
      grd_ff <= global_mem[gidx_rd];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         hist_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         lwr_valid_ff  <= 1'b0;
         gwr_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         hist_ff       <= hist_in;
         s1_valid_ff   <= s1_valid_in;
         lwr_valid_ff  <= lwr_valid_in;
         gwr_valid_ff  <= gwr_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_voted_ff <= req_data.is_cond || req_data.is_indir;
      s1_taken_ff <= req_data.outcome_taken;
      s1_lidx_ff  <= lidx_rd;
      s1_gidx_ff  <= gidx_rd;
      lwr_idx_ff  <= s1_lidx_ff;
      lwr_data_ff <= lnew;
      gwr_idx_ff  <= s1_gidx_ff;
      gwr_data_ff <= gnew;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the tournament branch predictor
module testbench;
   import tbp_pkg::*;

   localparam int CLK_HALF       = 2;
   localparam int RESET_CYCLES   = 12;
   localparam int N_DIRECTED     = 22;
   localparam int N_RANDOM       = 1528;
   localparam int CALM_TAIL      = 250;
   localparam int DRAIN_CYCLES   = 8;
   // covers the clearing pass after reset, plus a maximal idle burst
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LOCAL_DEPTH    = 1024;
   localparam int GLOBAL_DEPTH   = 4096;
   localparam int N_HOT          = 8;
   localparam int MAX_SHOWN      = 10;

   // one row of the directed table; want is only used when pinned is set
   typedef struct packed {
      req_type br;
      logic    pinned;
      rsp_type want;
   } step_row_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // model copy of the tables and history
   logic [2:0]  local_ctr   [LOCAL_DEPTH];
   logic [1:0]  global_ctr  [GLOBAL_DEPTH];
   logic [1:0]  chooser_ctr [GLOBAL_DEPTH];
   logic [11:0] outcome_hist;

   rsp_type pending_predictions [$];

   // typed-in expectation for the word currently offered
   logic    pin_valid = 1'b0;
   rsp_type pin_word  = '0;

   int mismatches     = 0;
   int idle_cycles    = 0;
   int branches_seen  = 0;
   int voted_seen     = 0;
   int global_picks   = 0;
   int words_checked  = 0;

   // hot branches for the well-formed part of the random stimulus
   logic [9:0] hot_pc   [N_HOT];
   logic [1:0] hot_kind [N_HOT];
   int         hot_len  [N_HOT];
   int         hot_trip [N_HOT];

   step_row_type directed_rows [N_DIRECTED] = '{
      '{'{10'd0,    1'b0, 1'b0, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0}},
      '{'{10'd1023, 1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{10'd1023, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{10'd1023, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'h2AA,  1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'h155,  1'b0, 1'b1, 1'b0}, 1'b0, '0}
   };

   tournament_branch_predictor dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // free-running clock
   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // saturating counter move toward the outcome
   function automatic int sat_move(input int v, input logic up, input int top);
      if (up) return (v < top) ? v + 1 : top;
      return (v > 0) ? v - 1 : 0;
   endfunction

   // prediction from the current tables, then training on the outcome
   function automatic rsp_type predict_and_train_branch(input req_type br);
      rsp_type p;
      logic    voted;
      logic    lv;
      logic    gv;
      logic    cg;
      logic    l_right;
      logic    g_right;
      int      li;
      int      gi;
      li    = int'(br.pc_index) % LOCAL_DEPTH;
      gi    = int'(outcome_hist) % GLOBAL_DEPTH;
      voted = br.is_cond | br.is_indir;
      lv    = local_ctr[li][2];
      gv    = global_ctr[gi][1];
      cg    = chooser_ctr[gi][1];
      p.local_vote      = lv;
      p.global_vote     = gv;
      p.chose_global    = voted & cg;
      p.predicted_taken = voted ? (cg ? gv : lv) : 1'b1;
      // chooser leans toward whichever vote alone was right
      l_right = (lv == br.outcome_taken);
      g_right = (gv == br.outcome_taken);
      if (g_right && !l_right)
         chooser_ctr[gi] = 2'(sat_move(int'(chooser_ctr[gi]), 1'b1, 3));
      else if (l_right && !g_right)
         chooser_ctr[gi] = 2'(sat_move(int'(chooser_ctr[gi]), 1'b0, 3));
      if (voted)
         local_ctr[li] = 3'(sat_move(int'(local_ctr[li]), br.outcome_taken, 7));
      global_ctr[gi] = 2'(sat_move(int'(global_ctr[gi]), br.outcome_taken, 3));
      outcome_hist = {outcome_hist[10:0], br.outcome_taken};
      return p;
   endfunction

   // one field of a response word against its expectation
   task automatic check_field(input string field, input logic want, input logic got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("%0t: %s mismatch, expected %b got %b", $realtime, field, want, got);
      end
   endtask

   // next random branch: mostly loop-like hot branches, the rest noise
   function automatic req_type pick_branch();
      req_type br;
      int      k;
      br = req_type'($urandom);
      if ($urandom_range(0, 99) < 65) begin
         k = $urandom_range(0, N_HOT - 1);
         br.pc_index = hot_pc[k];
         {br.is_indir, br.is_cond} = hot_kind[k];
         hot_trip[k]++;
         if (hot_trip[k] >= hot_len[k]) begin
            hot_trip[k] = 0;
            br.outcome_taken = 1'b0;
         end else begin
            br.outcome_taken = 1'b1;
         end
      end
      return br;
   endfunction

   // offer one word and hold it until taken
   task automatic send_branch(input req_type br, input logic pinned, input rsp_type want);
      pin_valid = pinned;
      pin_word  = want;
      start    <= 1'b1;
      req_data <= br;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // sender idles for a number of cycles, with noise on the data lines
   task automatic hold_off(input int cycles);
      start    <= 1'b0;
      req_data <= req_type'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   // response checking, prediction on acceptance, and the watchdog
   always @(posedge clock) begin
      rsp_type want;
      rsp_type guess;
      logic    moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_strobe) begin
            moved = 1'b1;
            if (pending_predictions.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("%0t: response word with nothing pending: %b", $realtime, rsp_data);
            end else begin
               want = pending_predictions.pop_front();
               words_checked++;
               check_field("predicted_taken", want.predicted_taken, rsp_data.predicted_taken);
               check_field("local_vote", want.local_vote, rsp_data.local_vote);
               check_field("global_vote", want.global_vote, rsp_data.global_vote);
               check_field("chose_global", want.chose_global, rsp_data.chose_global);
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            guess = predict_and_train_branch(req_data);
            pending_predictions.push_back(pin_valid ? pin_word : guess);
            branches_seen++;
            if (req_data.is_cond || req_data.is_indir) voted_seen++;
            if (guess.chose_global) global_picks++;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      // model state after reset
      foreach (local_ctr[i]) local_ctr[i] = LOCAL_RESET;
      foreach (global_ctr[i]) global_ctr[i] = GLOBAL_RESET;
      foreach (chooser_ctr[i]) chooser_ctr[i] = CHOOSER_RESET;
      outcome_hist = '0;
      for (int k = 0; k < N_HOT; k++) begin
         hot_pc[k]   = 10'($urandom_range(0, LOCAL_DEPTH - 1));
         hot_kind[k] = 2'($urandom_range(1, 3));
         hot_len[k]  = $urandom_range(2, 9);
         hot_trip[k] = 0;
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[r])
         send_branch(directed_rows[r].br, directed_rows[r].pinned, directed_rows[r].want);

      // random part, idle bursts except in the calm tail, and one drain halfway
      for (int n = 0; n < N_RANDOM; n++) begin
         send_branch(pick_branch(), 1'b0, '0);
         if (n == N_RANDOM / 2) begin
            // let the pipe run dry before carrying on
            start <= 1'b0;
            while (pending_predictions.size() != 0) @(negedge clock);
            @(negedge clock);
         end else if (n < N_RANDOM - CALM_TAIL && $urandom_range(0, 5) == 0) begin
            hold_off($urandom_range(1, 15));
         end
      end

      // drain
      start <= 1'b0;
      while (pending_predictions.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_predictions.size() != 0) begin
         $display("%0d predictions never answered", pending_predictions.size());
         mismatches += pending_predictions.size();
      end

      $display("covered %0d branches (%0d voted, %0d unconditional), %0d words checked",
               branches_seen, voted_seen, branches_seen - voted_seen, words_checked);
      $display("chooser picked the global vote %0d times; %0d field mismatches",
               global_picks, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/tbp_pkg.sv
rtl/tournament_branch_predictor.sv
dv/testbench.sv
